### sv/mersenne_twister_generator_core_macros.svh
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core assertion macros
// Clocked property shorthands shared by the generator core.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MTG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Constants, types and word functions of the MT19937 generator core.
// ----------------------------------------------------------------------------
package mtg_pkg;

  // table geometry
  localparam int unsigned MT_N  = 624;
  localparam int unsigned MT_M  = 397;
  localparam int unsigned IDX_W = $clog2(MT_N);

  // recurrence and tempering constants
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;

  typedef logic [IDX_W-1:0] idx_t;

  // item kinds after classification
  typedef enum logic [0:0] {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] seed;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FILL  = 3'b010,
    S_TWIST = 3'b100
  } back_state_t;

  typedef struct packed {
    logic fill_active;
    logic twist_active;
    logic seeded;
    idx_t pos;
  } back_status_t;

  // one twist step on the current, next and far words
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
  endfunction

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] k);
    logic [31:0] t;
    t = k ^ (k >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

### sv/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Input side: takes items, classifies them and substitutes the zero seed.
// ----------------------------------------------------------------------------
module mtg_front (
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_opcode,
  input  logic [31:0]  in_seed,
  input  logic         q_full,
  output logic         q_push,
  output mtg_pkg::cmd_t q_data
);
  import mtg_pkg::*;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify; a draw carries the default seed for a possible self-seed
  always_comb begin
    if (in_opcode) begin
      q_data.kind = CMD_SEED;
      q_data.seed = (in_seed == 32'd0) ? DEFAULT_SEED : in_seed;
    end else begin
      q_data.kind = CMD_DRAW;
      q_data.seed = DEFAULT_SEED;
    end
  end

endmodule

### sv/mtg_queue.sv
// ----------------------------------------------------------------------------
// mtg_queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module mtg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtg_pkg::cmd_t push_data,
  input  logic          pop,
  output mtg_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import mtg_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t              slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// Back end: state table memory, seeding sequencer, on-the-fly twist and
// tempering, and the output register.
// ----------------------------------------------------------------------------
module mtg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  mtg_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_random_word,
  output mtg_pkg::back_status_t status
);
  import mtg_pkg::*;

  // state table, undefined until seeded
  logic [31:0]  twister_mem [MT_N];

  back_state_t  state_r, state_nxt;
  logic         seeded_r, seeded_nxt;
  idx_t         pos_r, pos_nxt;
  idx_t         fill_idx_r, fill_idx_nxt;
  logic [31:0]  prev_r, prev_nxt;
  logic [31:0]  cur_r, cur_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_word_r, out_word_nxt;

  // memory port signals
  logic         mem_we;
  idx_t         mem_waddr;
  logic [31:0]  mem_wdata;
  idx_t         addr_nxt_word, addr_far_word;
  logic [IDX_W:0] far_sum;
  logic [31:0]  rd_nxt_r, rd_far_r;

  // per-step results
  logic [31:0]  fill_mix, fill_prod, fill_word;
  logic [31:0]  twist_res;
  logic         slot_free;

  // neighbor addresses of the word being generated
  assign addr_nxt_word = (pos_r == idx_t'(MT_N - 1)) ? '0 : pos_r + 1'b1;
  assign far_sum       = {1'b0, pos_r} + (IDX_W + 1)'(MT_M);
  assign addr_far_word = (far_sum >= (IDX_W + 1)'(MT_N)) ?
                         idx_t'(far_sum - (IDX_W + 1)'(MT_N)) : idx_t'(far_sum);

  // seeding recurrence step
  assign fill_mix  = prev_r ^ (prev_r >> 30);
  assign fill_prod = INIT_MULT * fill_mix;
  assign fill_word = fill_prod + {{(32 - IDX_W){1'b0}}, fill_idx_r};

  assign twist_res = twist_word(cur_r, rd_nxt_r, rd_far_r);
  assign slot_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    pos_nxt       = pos_r;
    fill_idx_nxt  = fill_idx_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = twist_res;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          priority if (cmd.kind == CMD_SEED || !seeded_r) begin
            // seed item, or a draw that needs a self-seed first
            cmd_pop      = (cmd.kind == CMD_SEED);
            mem_we       = 1'b1;
            mem_waddr    = '0;
            mem_wdata    = cmd.seed;
            prev_nxt     = cmd.seed;
            cur_nxt      = cmd.seed;
            fill_idx_nxt = idx_t'(1);
            state_nxt    = S_FILL;
          end else if (slot_free) begin
            cmd_pop   = 1'b1;
            state_nxt = S_TWIST;
          end else begin
            // draw waits for the output register
            state_nxt = S_IDLE;
          end
        end
      end
      S_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = fill_idx_r;
        mem_wdata    = fill_word;
        prev_nxt     = fill_word;
        fill_idx_nxt = fill_idx_r + 1'b1;
        if (fill_idx_r == idx_t'(MT_N - 1)) begin
          pos_nxt    = '0;
          seeded_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TWIST: begin
        // regenerate this word in place, prefetched neighbor becomes current
        mem_we        = 1'b1;
        mem_waddr     = pos_r;
        mem_wdata     = twist_res;
        cur_nxt       = rd_nxt_r;
        out_word_nxt  = temper(twist_res);
        out_valid_nxt = 1'b1;
        pos_nxt       = addr_nxt_word;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seeded_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    fill_idx_r <= fill_idx_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  // table write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      twister_mem[mem_waddr] <= mem_wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_nxt_r <= twister_mem[addr_nxt_word];
    rd_far_r <= twister_mem[addr_far_word];
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  assign status.fill_active  = (state_r == S_FILL);
  assign status.twist_active = (state_r == S_TWIST);
  assign status.seeded       = seeded_r;
  assign status.pos          = pos_r;

endmodule

### sv/mersenne_twister_generator_core.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core
// MT19937 32-bit pseudo-random word generator with seed and draw items.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, in_opcode, in_seed): opcode 1 reseeds the
// 624-word table from in_seed (0 means 4357) and gives no result; opcode 0
// draws one tempered word on the output channel (out_valid/out_ready,
// out_random_word). Items pass through a small queue, so input is taken
// while the back end is busy or a result waits on the output register.
// An accepted draw passes the queue, then the back end reads the next and far
// table words into registers in the idle state and twists, writes back and
// tempers the word into the output register in the twist state. The
// twist is done one word per draw, so there is no separate regeneration pass.
// A seed fills the table one word per cycle, word 0 from the seed and the rest
// via the init multiplier; a draw before any seed first fills with 4357.
// Reset clears the queue, the output valid and the seeded flags; the table
// itself is not cleared. When out_ready is low the result holds, the back end
// stops before the next draw and the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word
);
  import mtg_pkg::*;

`include "mersenne_twister_generator_core_macros.svh"

  logic         q_full, q_empty, q_push, q_pop;
  cmd_t         q_in, q_head;
  back_status_t bk_status;

  mtg_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_seed   (in_seed),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  mtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mtg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (!q_empty),
    .cmd             (q_head),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .status          (bk_status)
  );

  // checks
  `MTG_ASSERT_SAME(a_pos_in_table, 1'b1, bk_status.pos < idx_t'(MT_N), "table position out of range")
  `MTG_ASSERT_SAME(a_twist_seeded, bk_status.twist_active, bk_status.seeded, "twist on unseeded table")
  `MTG_ASSERT_NEXT(a_twist_result, bk_status.twist_active, out_valid, "twist gave no result")
  `MTG_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty, "queue popped while empty")
  `MTG_ASSERT_SAME(a_fill_no_pop, bk_status.fill_active, !q_pop, "queue popped during table fill")

endmodule
